FILE: hw/rtl/sha1_pkg.sv
// sha1_pkg: item types, phase codes, control bundle and SHA-1 constants.
// Used by every module of the sha1_hash_engine block; depends on nothing.
package sha1_pkg;

    // Input item: one message byte plus flags
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    // Result item: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ROUND,
        PH_FOLD,
        PH_PAD,
        PH_LEN,
        PH_OUT
    } t_phase;

    // Control bundle from the sequencer to the datapath
    typedef struct packed {
        logic       push_byte;
        logic [7:0] push_data;
        logic [1:0] byte_pos;
        logic       load_wv;
        logic       round_en;
        logic       fold;
        logic       clear;
        logic [6:0] round;
        logic [2:0] out_idx;
    } t_ctl;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [6:0] SCHED_LOAD  = 7'd16;
    localparam logic [6:0] GROUP1      = 7'd20;
    localparam logic [6:0] GROUP2      = 7'd40;
    localparam logic [6:0] GROUP3      = 7'd60;
    localparam logic [5:0] FILL_LEN    = 6'd56;
    localparam logic [5:0] FILL_LAST   = 6'd63;
    localparam logic [2:0] LAST_IDX    = 3'd4;
    localparam int         N_WORDS     = 5;

    // Initial chaining values
    function automatic logic [31:0] h_init(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hefcdab89;
            3'd2:    v = 32'h98badcfe;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hc3d2e1f0;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Round constant by round group
    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] v;
        if (rnd < GROUP1) begin
            v = 32'h5a827999;
        end else if (rnd < GROUP2) begin
            v = 32'h6ed9eba1;
        end else if (rnd < GROUP3) begin
            v = 32'h8f1bbcdc;
        end else begin
            v = 32'hca62c1d6;
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/sha1_sched.sv
// sha1_sched: byte packer and rolling 16-word message schedule shift line.
// Depends on sha1_pkg for the control bundle and schedule constants.
module sha1_sched
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  t_ctl        i_ctl,
    output logic [31:0] o_w
);

    logic [23:0] r_acc;
    logic [31:0] r_sw [16];
    logic [31:0] w_exp;

    // Expand the schedule from fixed taps: W[t-16], W[t-14], W[t-8], W[t-3]
    always_comb begin
        w_exp = r_sw[13] ^ r_sw[8] ^ r_sw[2] ^ r_sw[0];
        if (i_ctl.round < SCHED_LOAD) begin
            o_w = r_sw[0];
        end else begin
            o_w = {w_exp[30:0], w_exp[31]};
        end
    end

    // Pack bytes big-endian; shift a full word in, or roll the schedule per round
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_byte) begin
            r_acc <= {r_acc[15:0], i_ctl.push_data};
            if (i_ctl.byte_pos == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    r_sw[i] <= r_sw[i+1];
                end
                r_sw[15] <= {r_acc, i_ctl.push_data};
            end
        end else if (i_ctl.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_sw[i] <= r_sw[i+1];
            end
            r_sw[15] <= o_w;
        end
    end

endmodule

FILE: hw/rtl/sha1_core.sv
// sha1_core: shared round unit, working variables and chaining words.
// Depends on sha1_pkg for the control bundle, round constants and initial values.
module sha1_core
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  logic [31:0] i_w,
    output logic [31:0] o_digest
);

    logic [31:0] r_h  [N_WORDS];
    logic [31:0] r_wv [N_WORDS];
    logic [31:0] w_f;
    logic [31:0] w_t;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_c;
    logic [31:0] w_d;
    logic [31:0] w_e;

    assign w_a = r_wv[0];
    assign w_b = r_wv[1];
    assign w_c = r_wv[2];
    assign w_d = r_wv[3];
    assign w_e = r_wv[4];

    // Round function by group, then the five-term sum
    always_comb begin
        if (i_ctl.round < GROUP1) begin
            w_f = (w_b & w_c) ^ (~w_b & w_d);
        end else if (i_ctl.round >= GROUP2 && i_ctl.round < GROUP3) begin
            w_f = (w_b & w_c) ^ (w_b & w_d) ^ (w_c & w_d);
        end else begin
            w_f = w_b ^ w_c ^ w_d;
        end
        w_t = {w_a[26:0], w_a[31:27]} + w_f + w_e + round_k(i_ctl.round) + i_w;
    end

    // Working variables: load from chaining words, then one round per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_wv) begin
            for (int i = 0; i < N_WORDS; i++) begin
                r_wv[i] <= r_h[i];
            end
        end else if (i_ctl.round_en) begin
            r_wv[0] <= w_t;
            r_wv[1] <= w_a;
            r_wv[2] <= {w_b[1:0], w_b[31:2]};
            r_wv[3] <= w_c;
            r_wv[4] <= w_d;
        end
    end

    // Chaining words: restart on reset or after the digest, fold after a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int i = 0; i < N_WORDS; i++) begin
                r_h[i] <= h_init(3'(i));
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < N_WORDS; i++) begin
                r_h[i] <= r_h[i] + r_wv[i];
            end
        end
    end

    assign o_digest = r_h[i_ctl.out_idx];

endmodule

FILE: hw/rtl/sha1_ctrl.sv
// sha1_ctrl: sequencer for byte intake, padding, rounds and digest output.
// Depends on sha1_pkg for phase codes, item types and the control bundle.
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ctl     o_ctl
);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [6:0]  r_round, n_round;
    logic        r_fin, n_fin;
    logic        r_mark, n_mark;
    logic        r_lendone, n_lendone;
    logic [2:0]  r_widx, n_widx;
    logic        w_inj;
    logic [7:0]  w_inj_byte;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_round   <= '0;
            r_fin     <= 1'b0;
            r_mark    <= 1'b0;
            r_lendone <= 1'b0;
            r_widx    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_fill    <= n_fill;
            r_bits    <= n_bits;
            r_round   <= n_round;
            r_fin     <= n_fin;
            r_mark    <= n_mark;
            r_lendone <= n_lendone;
            r_widx    <= n_widx;
        end
    end

    // Next state and control
    always_comb begin
        n_phase    = r_phase;
        n_fill     = r_fill;
        n_bits     = r_bits;
        n_round    = r_round;
        n_fin      = r_fin;
        n_mark     = r_mark;
        n_lendone  = r_lendone;
        n_widx     = r_widx;
        w_inj      = 1'b0;
        w_inj_byte = '0;
        o_ctl      = '0;
        o_ctl.round    = r_round;
        o_ctl.byte_pos = r_fill[1:0];
        o_ctl.out_idx  = r_widx;
        o_in_ready  = (r_phase == PH_IDLE);
        o_out_valid = (r_phase == PH_OUT);

        case (r_phase)
            PH_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.has_byte) begin
                        w_inj      = 1'b1;
                        w_inj_byte = i_in.msg_byte;
                        n_bits     = r_bits + 64'd8;
                    end
                    if (i_in.end_of_message) begin
                        n_fin   = 1'b1;
                        n_phase = PH_PAD;
                    end
                end
            end
            PH_PAD: begin
                // Marker byte first, then zeros up to the length field
                if (r_mark && r_fill == FILL_LEN) begin
                    n_phase = PH_LEN;
                end else begin
                    w_inj      = 1'b1;
                    w_inj_byte = r_mark ? 8'h00 : PAD_BYTE;
                    n_mark     = 1'b1;
                end
            end
            PH_LEN: begin
                // Feed the bit count, most significant byte first
                w_inj      = 1'b1;
                w_inj_byte = r_bits[63:56];
                n_bits     = {r_bits[55:0], 8'h00};
                if (r_fill == FILL_LAST) begin
                    n_lendone = 1'b1;
                end
            end
            PH_ROUND: begin
                o_ctl.round_en = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_phase = PH_FOLD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            PH_FOLD: begin
                o_ctl.fold = 1'b1;
                if (!r_fin) begin
                    n_phase = PH_IDLE;
                end else if (r_lendone) begin
                    n_phase = PH_OUT;
                end else begin
                    n_phase = PH_PAD;
                end
            end
            PH_OUT: begin
                if (i_out_ready) begin
                    if (r_widx == LAST_IDX) begin
                        o_ctl.clear = 1'b1;
                        n_widx    = '0;
                        n_fill    = '0;
                        n_bits    = '0;
                        n_fin     = 1'b0;
                        n_mark    = 1'b0;
                        n_lendone = 1'b0;
                        n_phase   = PH_IDLE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Push the byte; a full block starts the rounds
        if (w_inj) begin
            o_ctl.push_byte = 1'b1;
            o_ctl.push_data = w_inj_byte;
            n_fill          = r_fill + 6'd1;
            if (r_fill == FILL_LAST) begin
                o_ctl.load_wv = 1'b1;
                n_round       = '0;
                n_phase       = PH_ROUND;
            end
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output handshakes open together");

    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_ROUND) |-> (r_round == 7'd0))
        else $error("round counter not parked outside compression");

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ROUND && r_round == LAST_ROUND) |=> (r_phase == PH_FOLD))
        else $error("compression did not end in fold");

    a_out_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OUT) |-> (r_fill == 6'd0 && r_lendone))
        else $error("digest output with a partial block");

    a_eom_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.end_of_message) |=> (r_phase != PH_IDLE))
        else $error("end of message item left the engine idle");

endmodule

FILE: hw/rtl/sha1_hash_engine.sv
// sha1_hash_engine: SHA-1 over a byte stream, five digest words per message.
// Depends on sha1_pkg, sha1_sched, sha1_core and sha1_ctrl.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+------------------------------
//   input   | i_in_valid   | o_in_ready   | i_in  (t_in_item, one byte)
//   output  | o_out_valid  | i_out_ready  | o_out (t_out_item, one word)
//
// A byte that does not complete a block is only packed; the 64th byte also
// starts a compression, the rounds and then a fold, in the shared round unit.
// End of message feeds padding and the bit count one byte per cycle, except
// during compressions, with a switch step before the count; one or two
// compressions and five output words, one per handshake. Reset (synchronous,
// active low) loads the initial chaining words; input waits while busy.
module sha1_hash_engine
    import sha1_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_ctl        w_ctl;
    logic [31:0] w_w;
    logic [31:0] w_digest;

    sha1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (w_ctl)
    );

    sha1_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_w   (w_w)
    );

    sha1_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_w      (w_w),
        .o_digest (w_digest)
    );

    // Digest word from the chaining registers, indexed by the output counter
    always_comb begin
        o_out.digest_word = w_digest;
        o_out.word_index  = w_ctl.out_idx;
        o_out.last_word   = (w_ctl.out_idx == LAST_IDX);
    end

endmodule

FILE: test/sha1_hash_engine_test.sv
// sha1_hash_engine_test: self-checking testbench for the SHA-1 byte-stream engine.
// A queue-fed driver, a digest predictor and an output monitor live in this top module.
// Depends on sha1_pkg and the sha1_hash_engine RTL.
`timescale 1ns / 1ps

module sha1_hash_engine_test;
    import sha1_pkg::*;

    // Idling schedule: which side idles, by stimulus progress
    typedef enum logic [1:0] {
        MODE_RECV_SLOW,
        MODE_SEND_SLOW,
        MODE_NO_IDLE
    } t_idle_mode;

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 4;
    localparam int          RANDOM_ITEMS = 220;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [63:0] BYTE_BITS    = 64'd8;

    localparam logic [31:0] CHAIN_SEED [0:4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] ROUND_CONST [0:3] = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    sha1_hash_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // Digest predictor state
    logic [31:0] chain_words [0:4];
    logic [31:0] block_buf [0:15];
    logic [5:0]  fill_bytes;
    logic [63:0] msg_bit_len;

    t_in_item    pending_items[$];
    t_out_item   expected_words[$];

    int          stim_count = 0;
    int          accepted_count = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    logic        driving = 1'b0;
    logic        in_taken = 1'b0;
    logic        pressure_req = 1'b0;
    logic        pressure_done = 1'b0;
    int          hold_left = 0;

    // Clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_idle_mode idle_mode();
        if (accepted_count < stim_count / 3) begin
            return MODE_RECV_SLOW;
        end else if (accepted_count < (2 * stim_count) / 3) begin
            return MODE_SEND_SLOW;
        end
        return MODE_NO_IDLE;
    endfunction

    task automatic restart_chain();
        for (int i = 0; i < 5; i++) begin
            chain_words[i] = CHAIN_SEED[i];
        end
        fill_bytes  = '0;
        msg_bit_len = '0;
    endtask

    // Run the 80 rounds over block_buf and fold into the chaining words
    task automatic compress_block();
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) begin
            w[r] = block_buf[r];
        end
        for (int r = 16; r < 80; r++) begin
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
            end else if (r < 40 || r >= 60) begin
                f = b ^ c ^ d;
            end else begin
                f = (b & c) | (b & d) | (c & d);
            end
            k = ROUND_CONST[r / 20];
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endtask

    // Pack one byte big-endian at the current fill position
    task automatic pack_byte(input logic [7:0] data);
        logic [3:0]  widx;
        logic [31:0] lane;
        widx = fill_bytes[5:2];
        lane = {24'd0, data} << (8 * (3 - fill_bytes[1:0]));
        if (fill_bytes[1:0] == 2'd0) begin
            block_buf[widx] = lane;
        end else begin
            block_buf[widx] |= lane;
        end
    endtask

    // Absorb one accepted item; on end of message queue the five digest words
    task automatic absorb_item(input t_in_item it);
        t_out_item word;
        if (it.has_byte) begin
            pack_byte(it.msg_byte);
            msg_bit_len += BYTE_BITS;
            fill_bytes  += 6'd1;
            if (fill_bytes == 6'd0) begin
                compress_block();
            end
        end
        if (it.end_of_message) begin
            pack_byte(PAD_BYTE);
            for (int i = fill_bytes[5:2] + 1; i < 16; i++) begin
                block_buf[i] = '0;
            end
            // Length does not fit behind the pad byte: spill into a second block
            if (fill_bytes >= FILL_LEN) begin
                compress_block();
                for (int i = 0; i < 14; i++) begin
                    block_buf[i] = '0;
                end
            end
            block_buf[14] = msg_bit_len[63:32];
            block_buf[15] = msg_bit_len[31:0];
            compress_block();
            for (int i = 0; i < N_WORDS; i++) begin
                word.digest_word = chain_words[i];
                word.word_index  = 3'(i);
                word.last_word   = (3'(i) == LAST_IDX);
                expected_words.push_back(word);
            end
            restart_chain();
        end
    endtask

    task automatic add_item(input logic [7:0] data, input logic has, input logic eom);
        t_in_item it;
        it.msg_byte       = data;
        it.has_byte       = has;
        it.end_of_message = eom;
        pending_items.push_back(it);
        if (has || eom) begin
            stim_count++;
        end
    endtask

    // Queue one message of len bytes, optionally closed by a separate byte-less item
    task automatic add_message(input int len, input logic split_end, input int noise_pct);
        logic close_apart;
        close_apart = split_end || (len == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                add_item(8'($urandom), 1'b0, 1'b0);
            end
            add_item(8'($urandom), 1'b1, !close_apart && (i == len - 1));
        end
        if (close_apart) begin
            add_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Monitor: predict on accepted input items, check accepted result items
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken = i_in_valid && o_in_ready;
        if (in_taken) begin
            absorb_item(i_in);
            if (i_in.has_byte || i_in.end_of_message) begin
                accepted_count++;
            end
            if (i_in.end_of_message && idle_mode() == MODE_NO_IDLE && !pressure_done) begin
                pressure_req = 1'b1;
            end
        end
        if (o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected digest word %h (index %0d)", o_out.digest_word,
                       o_out.word_index);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_out.digest_word !== want.digest_word) begin
                    $error("digest_word: expected %h, got %h", want.digest_word,
                           o_out.digest_word);
                    fail_count++;
                end
                if (o_out.word_index !== want.word_index) begin
                    $error("word_index: expected %0d, got %0d", want.word_index,
                           o_out.word_index);
                    fail_count++;
                end
                if (o_out.last_word !== want.last_word) begin
                    $error("last_word: expected %0b, got %0b", want.last_word,
                           o_out.last_word);
                    fail_count++;
                end
            end
        end
    end

    // Driver: hold the offered item until taken, then pop the next or idle
    always @(negedge i_clk) begin
        if (i_in_valid && !in_taken) begin
            // hold
        end else if (driving && pending_items.size() != 0
                     && !(idle_mode() == MODE_RECV_SLOW && $urandom_range(99) < 13)
                     && !(idle_mode() == MODE_SEND_SLOW && $urandom_range(99) < 84)) begin
            i_in       <= pending_items.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off once, right after a message end in the no-idle stretch
    always @(negedge i_clk) begin
        if (pressure_req && !pressure_done) begin
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready
    always @(negedge i_clk) begin
        if (!driving || hold_left > 0) begin
            i_out_ready <= 1'b0;
        end else if (idle_mode() == MODE_RECV_SLOW) begin
            i_out_ready <= ($urandom_range(99) >= 84);
        end else if (idle_mode() == MODE_SEND_SLOW) begin
            i_out_ready <= ($urandom_range(99) >= 13);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int len;
        int pick;
        restart_chain();
        for (int i = 0; i < 16; i++) begin
            block_buf[i] = '0;
        end

        // Directed: ignored item, empty message, short messages, extreme bytes
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'ha5, 1'b0, 1'b1);
        add_item(8'h61, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h63, 1'b1, 1'b1);
        add_item(8'h00, 1'b1, 1'b1);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'h5a, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h80, 1'b1, 1'b0);
        add_item(8'h7f, 1'b1, 1'b0);
        add_item(8'h01, 1'b1, 1'b1);

        // Random messages: mostly short, some around the padding boundaries
        while (stim_count < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                len = $urandom_range(6);
            end else if (pick < 88) begin
                len = $urandom_range(66, 52);
            end else begin
                len = $urandom_range(130, 7);
            end
            add_message(len, $urandom_range(1), 8);
        end

        // Reset, released on a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        driving <= 1'b1;

        // Drain: all items accepted, all results seen, then a quiet stretch
        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
